@@ hw/rtl/punrank_pkg.sv @@
// Shared types and constants for the permutation unranking block.
// Used by the channel interfaces, the divider, the symbol store and the top level.
// No dependencies.
package punrank_pkg;

  localparam int RANK_W              = 45;
  localparam int WORD_W              = 64;
  localparam int BYTE_W              = 8;
  localparam int KEY_BYTES           = 16;
  localparam int WORD_BYTES          = 8;
  localparam int CNT_W               = 5;
  localparam int POS_W               = 4;
  localparam int DIV_W               = 5;
  localparam int CFG_IDX_W           = 2;
  localparam int DIV_STEP            = 5;
  localparam int DIV_ITERS           = 9;
  localparam int DIV_CNT_W           = 4;
  localparam int DEFAULT_MAX_SYMBOLS = 16;
  localparam logic [CNT_W-1:0] COUNT_RESET = 5'd16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SYMBOL_COUNT = 2'd0,
    REG_KEY_LOW      = 2'd1,
    REG_KEY_HIGH     = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_FETCH,
    ST_SWAP,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic [RANK_W-1:0] dividend;
    logic [DIV_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              busy;
    logic [RANK_W-1:0] quotient;
    logic [POS_W-1:0]  remainder;
  } div_rsp_t;

  typedef struct packed {
    logic             load;
    logic             fetch;
    logic             swap;
    logic [POS_W-1:0] pos_p;
    logic [POS_W-1:0] pos_j;
  } sym_cmd_t;

endpackage

@@ hw/rtl/punrank_if.sv @@
// Valid/ready channel interfaces: rank input, permuted word output, register writes.
// Depends on punrank_pkg.
interface punrank_in_if import punrank_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [RANK_W-1:0] rank;

  modport source (output valid, output rank, input ready);
  modport sink   (input valid, input rank, output ready);
endinterface

interface punrank_out_if import punrank_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] perm_bytes_low;
  logic [WORD_W-1:0] perm_bytes_high;

  modport source (output valid, output perm_bytes_low, output perm_bytes_high, input ready);
  modport sink   (input valid, input perm_bytes_low, input perm_bytes_high, output ready);
endinterface

interface punrank_cfg_if import punrank_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [WORD_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/punrank_div.sv @@
// Shared small-divisor divider: rank / (j+1), DIV_STEP quotient bits per cycle.
// Depends on punrank_pkg.
module punrank_div import punrank_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [RANK_W-1:0]    quo_q;
  logic [POS_W-1:0]     rem_q;
  logic [DIV_W-1:0]     dvs_q;
  logic [RANK_W-1:0]    quo_step;
  logic [POS_W-1:0]     rem_step;
  logic [DIV_W-1:0]     trial;

  // Restoring long division, MSB first; remainder stays below the divisor.
  always_comb begin
    quo_step = quo_q;
    rem_step = rem_q;
    trial    = '0;
    for (int k = 0; k < DIV_STEP; k++) begin
      trial    = {rem_step, quo_step[RANK_W-1]};
      quo_step = {quo_step[RANK_W-2:0], 1'b0};
      if (trial >= dvs_q) begin
        trial       = trial - dvs_q;
        quo_step[0] = 1'b1;
      end
      rem_step = trial[POS_W-1:0];
    end
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(DIV_ITERS);
    end else if (busy_q) begin
      cnt_d = cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      quo_q <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      quo_q <= quo_step;
      rem_q <= rem_step;
    end
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.busy      = busy_q;
  assign rsp_o.quotient  = quo_q;
  assign rsp_o.remainder = rem_q;

`ifndef SYNTH
  a_no_start_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q)
    else $error("divider started while busy");

  a_done_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider done without a finished run");
`endif

endmodule

@@ hw/rtl/punrank_sym.sv @@
// Symbol store: 16 byte registers loaded from the key, swapped one pair at a time.
// Single read port: fetch grabs symbol p, swap reads symbol j and writes both.
// Depends on punrank_pkg.
module punrank_sym import punrank_pkg::*; (
  input  logic              clk_i,
  input  sym_cmd_t          cmd_i,
  input  logic [WORD_W-1:0] key_low_i,
  input  logic [WORD_W-1:0] key_high_i,
  output logic [WORD_W-1:0] sym_low_o,
  output logic [WORD_W-1:0] sym_high_o
);

  logic [BYTE_W-1:0] sym_q [KEY_BYTES];
  logic [BYTE_W-1:0] sym_d [KEY_BYTES];
  logic [BYTE_W-1:0] hold_q, hold_d;
  logic [POS_W-1:0]  rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign rd_addr = cmd_i.swap ? cmd_i.pos_j : cmd_i.pos_p;
  assign rd_data = sym_q[rd_addr];

  always_comb begin
    sym_d  = sym_q;
    hold_d = hold_q;
    if (cmd_i.load) begin
      for (int i = 0; i < WORD_BYTES; i++) begin
        sym_d[i]              = key_low_i[BYTE_W*i +: BYTE_W];
        sym_d[i + WORD_BYTES] = key_high_i[BYTE_W*i +: BYTE_W];
      end
    end else if (cmd_i.swap) begin
      sym_d[cmd_i.pos_p] = rd_data;
      sym_d[cmd_i.pos_j] = hold_q;
    end
    if (cmd_i.fetch) begin
      hold_d = rd_data;
    end
  end

  always_ff @(posedge clk_i) begin
    sym_q  <= sym_d;
    hold_q <= hold_d;
  end

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      sym_low_o[BYTE_W*i +: BYTE_W]  = sym_q[i];
      sym_high_o[BYTE_W*i +: BYTE_W] = sym_q[i + WORD_BYTES];
    end
  end

endmodule

@@ hw/rtl/permutation_unrank.sv @@
// Top level of the permutation unranking block: registers, sequencer, output register.
// Depends on punrank_pkg, punrank_if, punrank_div and punrank_sym.
//
// Usage:
//   cfg_i : register writes (0 symbol count, 1 key bytes 0-7, 2 key bytes 8-15),
//           always ready; write only while no rank is in flight. Index 3 is dropped.
//   in_i  : one 45-bit rank per word. Ready only while the sequencer is idle.
//   out_o : the key bytes rearranged by factorial-base unranking, packed as the key.
// Each symbol position j = 1 .. count-1 runs a division in the shared divider
// (5 quotient bits per cycle over the 45-bit rank), waits for its done flag,
// then fetches symbol p and swaps. A count of 0 or 1 skips the divider and
// goes straight to the done state. The count is clamped to MAX_SYMBOLS and to 16.
// One rank is in work at a time;
// the output register lets the next rank be accepted while a result still waits.
// If the receiver stalls with a result held, a finished rank waits in the done
// state until the output register frees up.
// Reset: count 16, key all zero, no word pending on either channel.
module permutation_unrank import punrank_pkg::*; #(
  parameter int MAX_SYMBOLS = DEFAULT_MAX_SYMBOLS
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  punrank_in_if.sink    in_i,
  punrank_out_if.source out_o,
  punrank_cfg_if.sink   cfg_i
);

  localparam int LIMIT = (MAX_SYMBOLS < KEY_BYTES) ? MAX_SYMBOLS : KEY_BYTES;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q;
  logic [WORD_W-1:0] key_low_q, key_high_q;
  logic [POS_W-1:0]  j_q, j_d;
  logic              out_valid_q, out_valid_d;
  logic [WORD_W-1:0] out_low_q, out_high_q;
  logic [WORD_W-1:0] sym_low, sym_high;
  logic [CNT_W-1:0]  n_eff;
  logic              last_pos;
  logic              in_accept;
  logic              out_load;
  div_req_t          div_req;
  div_rsp_t          div_rsp;
  sym_cmd_t          sym_cmd;

  // Configuration registers
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= COUNT_RESET;
      key_low_q  <= '0;
      key_high_q <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_SYMBOL_COUNT: count_q    <= cfg_i.data[CNT_W-1:0];
        REG_KEY_LOW:      key_low_q  <= cfg_i.data;
        REG_KEY_HIGH:     key_high_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign n_eff    = (count_q > CNT_W'(LIMIT)) ? CNT_W'(LIMIT) : count_q;
  assign last_pos = ((CNT_W'(j_q) + CNT_W'(1)) == n_eff);

  // Next-state logic
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = (n_eff <= CNT_W'(1)) ? ST_DONE : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          state_d = ST_FETCH;
        end
      end
      ST_FETCH: state_d = ST_SWAP;
      ST_SWAP:  state_d = last_pos ? ST_DONE : ST_DIV;
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output logic
  always_comb begin
    in_i.ready       = 1'b0;
    j_d              = j_q;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = div_rsp.quotient;
    div_req.divisor  = DIV_W'(j_q) + DIV_W'(2);
    sym_cmd.load     = 1'b0;
    sym_cmd.fetch    = 1'b0;
    sym_cmd.swap     = 1'b0;
    sym_cmd.pos_p    = div_rsp.remainder;
    sym_cmd.pos_j    = j_q;
    unique case (state_q)
      ST_IDLE: begin
        in_i.ready       = 1'b1;
        div_req.dividend = in_i.rank;
        div_req.divisor  = DIV_W'(2);
        if (in_i.valid) begin
          sym_cmd.load  = 1'b1;
          j_d           = POS_W'(1);
          div_req.start = (n_eff > CNT_W'(1));
        end
      end
      ST_FETCH: sym_cmd.fetch = 1'b1;
      ST_SWAP: begin
        sym_cmd.swap = 1'b1;
        if (!last_pos) begin
          j_d           = j_q + POS_W'(1);
          div_req.start = 1'b1;
        end
      end
      ST_DONE:  out_load = !out_valid_q || out_o.ready;
      ST_DIV: ;
      default: ;
    endcase
  end

  assign in_accept   = in_i.valid && in_i.ready;
  assign out_valid_d = out_load || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_low_q  <= sym_low;
      out_high_q <= sym_high;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.perm_bytes_low  = out_low_q;
  assign out_o.perm_bytes_high = out_high_q;

  punrank_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  punrank_sym u_sym (
    .clk_i      (clk_i),
    .cmd_i      (sym_cmd),
    .key_low_i  (key_low_q),
    .key_high_i (key_high_q),
    .sym_low_o  (sym_low),
    .sym_high_o (sym_high)
  );

`ifndef SYNTH
  a_swap_after_fetch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sym_cmd.swap |-> $past(sym_cmd.fetch))
    else $error("swap issued without a fetch of symbol p");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> ((CNT_W'(j_q) < n_eff) && (j_q != '0)))
    else $error("symbol position outside the active count");

  a_no_accept_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |-> (!div_rsp.busy && (state_q == ST_IDLE)))
    else $error("rank accepted while a rank is in work");
`endif

endmodule

@@ tb/sv/tb_top.sv @@
// Testbench for permutation_unrank: drives ranks and register writes, predicts each
// permuted key word and checks it against the block's output channel.
// Depends on punrank_pkg, the channel interfaces in punrank_if and the RTL top level.
module tb_top import punrank_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0] lo;
    logic [WORD_W-1:0] hi;
  } perm_word_t;

  typedef enum int {
    IDLE_SEND_LIGHT,
    IDLE_SEND_HEAVY,
    IDLE_NONE
  } idle_mode_e;

  // The index right past the register list; the block drops writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int TAIL_CYCLES   = 400;
  localparam int DRAIN_LIMIT   = 20000;
  localparam int RANDOM_ITEMS  = 412;

  logic clk_i;
  logic rst_ni;

  punrank_in_if  in_if ();
  punrank_out_if out_if ();
  punrank_cfg_if cfg_if ();

  permutation_unrank u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Shadow registers of the block.
  logic [CNT_W-1:0]  sym_count_r;
  logic [WORD_W-1:0] key_lo_r;
  logic [WORD_W-1:0] key_hi_r;

  perm_word_t perm_q[$];
  int error_count;
  int send_idle_pct;
  int recv_idle_pct;

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.rank = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_SYMBOL_COUNT;
    cfg_if.data = '0;
  end

  always #1 clk_i = ~clk_i;

  initial begin
    #4_000_000;
    $display("FAIL permutation_unrank");
    $finish;
  end

  function automatic int eff_count();
    int n;
    n = int'(sym_count_r);
    if (n > DEFAULT_MAX_SYMBOLS) n = DEFAULT_MAX_SYMBOLS;
    if (n > KEY_BYTES) n = KEY_BYTES;
    return n;
  endfunction

  function automatic logic [RANK_W-1:0] fact_of(int n);
    logic [RANK_W-1:0] f;
    f = RANK_W'(1);
    for (int k = 2; k <= n; k++) f = f * RANK_W'(k);
    return f;
  endfunction

  function automatic perm_word_t unrank_perm(logic [RANK_W-1:0] rank);
    logic [BYTE_W-1:0] sym [KEY_BYTES];
    logic [BYTE_W-1:0] t;
    logic [RANK_W-1:0] r;
    int n;
    int p;
    perm_word_t w;
    r = rank;
    n = eff_count();
    for (int i = 0; i < WORD_BYTES; i++) begin
      sym[i] = key_lo_r[BYTE_W*i +: BYTE_W];
      sym[i+WORD_BYTES] = key_hi_r[BYTE_W*i +: BYTE_W];
    end
    for (int j = 1; j < n; j++) begin
      p = int'(r % RANK_W'(j + 1));
      t = sym[p];
      sym[p] = sym[j];
      sym[j] = t;
      r = r / RANK_W'(j + 1);
    end
    for (int i = 0; i < WORD_BYTES; i++) begin
      w.lo[BYTE_W*i +: BYTE_W] = sym[i];
      w.hi[BYTE_W*i +: BYTE_W] = sym[i+WORD_BYTES];
    end
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  task automatic report_mismatch(string what, logic [WORD_W-1:0] got, logic [WORD_W-1:0] want);
    $display("[%0t] mismatch %s: got %h, want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Check every accepted output word against the oldest prediction.
  always @(posedge clk_i) begin
    perm_word_t want;
    if (out_if.valid && out_if.ready) begin
      if (perm_q.size() == 0) begin
        report_mismatch("unexpected word, low", out_if.perm_bytes_low, '0);
      end else begin
        want = perm_q.pop_front();
        if (out_if.perm_bytes_low !== want.lo)
          report_mismatch("perm_bytes_low", out_if.perm_bytes_low, want.lo);
        if (out_if.perm_bytes_high !== want.hi)
          report_mismatch("perm_bytes_high", out_if.perm_bytes_high, want.hi);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic set_idling(idle_mode_e mode);
    case (mode)
      IDLE_SEND_LIGHT: begin
        send_idle_pct = 17;
        recv_idle_pct = 66;
      end
      IDLE_SEND_HEAVY: begin
        send_idle_pct = 66;
        recv_idle_pct = 17;
      end
      default: begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
    endcase
  endtask

  task automatic send_rank(logic [RANK_W-1:0] rank);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.rank <= rank;
    do @(posedge clk_i); while (!in_if.ready);
    perm_q.insert(perm_q.size(), unrank_perm(rank));
  endtask

  // Hold the sender until every predicted word has come back.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (perm_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [WORD_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (index)
      REG_SYMBOL_COUNT: sym_count_r = data[CNT_W-1:0];
      REG_KEY_LOW:      key_lo_r = data;
      REG_KEY_HIGH:     key_hi_r = data;
      default: ;
    endcase
  endtask

  task automatic test_reset_state();
    send_rank('0);
    send_rank('1);
    wait_idle();
  endtask

  task automatic test_edge_cases();
    write_reg(REG_KEY_LOW, 64'h0706_0504_0302_0100);
    write_reg(REG_KEY_HIGH, 64'h0f0e_0d0c_0b0a_0908);
    send_rank('0);
    send_rank(RANK_W'(1));
    send_rank(fact_of(KEY_BYTES) - 1);
    send_rank(fact_of(KEY_BYTES));
    send_rank('1);
    wait_idle();
    // empty and single-symbol strings come back as the key
    write_reg(REG_SYMBOL_COUNT, 64'hffff_ffff_ffff_ffe0);
    send_rank(RANK_W'(rand_word()));
    wait_idle();
    write_reg(REG_SYMBOL_COUNT, 64'd1);
    send_rank('1);
    wait_idle();
    write_reg(REG_SYMBOL_COUNT, 64'd2);
    send_rank(RANK_W'(0));
    send_rank(RANK_W'(1));
    send_rank(RANK_W'(2));
    wait_idle();
    // counts past the limit saturate
    write_reg(REG_SYMBOL_COUNT, 64'd31);
    send_rank(fact_of(KEY_BYTES) - 1);
    wait_idle();
    write_reg(REG_SYMBOL_COUNT, 64'd17);
    send_rank(RANK_W'(rand_word()));
    wait_idle();
    write_reg(REG_SYMBOL_COUNT, 64'd8);
    write_reg(REG_KEY_LOW, '1);
    write_reg(REG_KEY_HIGH, 64'haaaa_5555_aaaa_5555);
    send_rank(RANK_W'(5));
    wait_idle();
    // a write past the register list must change nothing
    write_reg(REG_UNUSED, rand_word());
    write_reg(REG_SYMBOL_COUNT, 64'd16);
    write_reg(REG_UNUSED, '0);
    send_rank(RANK_W'(rand_word()));
    send_rank(fact_of(KEY_BYTES) / 2);
    wait_idle();
  endtask

  task automatic test_random_traffic(idle_mode_e mode, int n_items);
    int sent;
    int batch;
    int sel;
    logic [BYTE_W-1:0] salt;
    logic [WORD_W-1:0] cnt_word;
    logic [RANK_W-1:0] rank;
    sent = 0;
    set_idling(mode);
    while (sent < n_items) begin
      wait_idle();
      cnt_word = rand_word();
      sel = $urandom_range(9);
      if (sel < 2) cnt_word[CNT_W-1:0] = CNT_W'(KEY_BYTES);
      else if (sel == 2) cnt_word[CNT_W-1:0] = '1;
      else if (sel == 3) cnt_word[CNT_W-1:0] = '0;
      write_reg(REG_SYMBOL_COUNT, cnt_word);
      if ($urandom_range(1) == 0) begin
        write_reg(REG_KEY_LOW, rand_word());
        write_reg(REG_KEY_HIGH, rand_word());
      end else begin
        // distinct symbols make every swap visible
        salt = BYTE_W'($urandom());
        for (int i = 0; i < WORD_BYTES; i++) begin
          cnt_word[BYTE_W*i +: BYTE_W] = BYTE_W'(i) ^ salt;
        end
        write_reg(REG_KEY_LOW, cnt_word);
        for (int i = 0; i < WORD_BYTES; i++) begin
          cnt_word[BYTE_W*i +: BYTE_W] = BYTE_W'(i + WORD_BYTES) ^ salt;
        end
        write_reg(REG_KEY_HIGH, cnt_word);
      end
      batch = $urandom_range(20, 60);
      for (int k = 0; k < batch && sent < n_items; k++) begin
        sel = $urandom_range(99);
        if (sel < 70) rank = RANK_W'(rand_word() % 64'(fact_of(eff_count())));
        else if (sel < 85) rank = RANK_W'(rand_word());
        else if (sel < 90) rank = '0;
        else if (sel < 95) rank = fact_of(eff_count()) - 1;
        else rank = '1;
        send_rank(rank);
        sent++;
      end
    end
    wait_idle();
  endtask

  initial begin
    int waited;
    error_count = 0;
    sym_count_r = COUNT_RESET;
    key_lo_r = '0;
    key_hi_r = '0;
    set_idling(IDLE_SEND_LIGHT);
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_edge_cases();
    test_random_traffic(IDLE_SEND_LIGHT, RANDOM_ITEMS);
    test_random_traffic(IDLE_SEND_HEAVY, RANDOM_ITEMS);
    test_random_traffic(IDLE_NONE, RANDOM_ITEMS);

    in_if.valid <= 1'b0;
    waited = 0;
    while (perm_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    while (perm_q.size() != 0) begin
      perm_word_t want;
      want = perm_q.pop_front();
      report_mismatch("missing word, low", 'x, want.lo);
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS permutation_unrank");
    end else begin
      $display("FAIL permutation_unrank");
    end
    $finish;
  end
endmodule
